/* src/gfti_pkg.sv */
// Shared types, constants and the step program of the trilinear field interpolator.
package gfti_pkg;

	localparam int RW          = 51;
	localparam int RA_W        = 4;
	localparam int RF_DEPTH    = 16;
	localparam int MA_W        = 35;
	localparam int MB_W        = 17;
	localparam int PW          = 52;
	localparam int FW          = 16;
	localparam int JW          = 8;
	localparam int DW          = 48;
	localparam int SAW         = 15;
	localparam int STORE_DEPTH = 32768;
	localparam int POS_LEN     = 9;
	localparam int PROG_LEN    = 43;
	localparam int PC_W        = 6;
	localparam int LD_W        = 4;
	localparam int LD_LAST     = 8;

	localparam logic [2:0] CFG_MAP_VALID = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_X  = 3'd1;
	localparam logic [2:0] CFG_ORIGIN_Y  = 3'd2;
	localparam logic [2:0] CFG_ORIGIN_Z  = 3'd3;
	localparam logic [2:0] CFG_INV_X     = 3'd4;
	localparam logic [2:0] CFG_INV_Y     = 3'd5;
	localparam logic [2:0] CFG_INV_Z     = 3'd6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {K_SUB, K_BLD, K_SLO, K_SHI, K_PSUB} kind_t;
	typedef enum logic [2:0] {RES_NONE, RES_PNEG, RES_PQ, RES_FLD, RES_DX, RES_DY, RES_DZ} res_t;
	typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_WB, S_CHK, S_LOAD, S_DONE} state_t;

	typedef struct packed {
		kind_t           kind;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
		logic [RA_W-1:0] rd;
		logic [1:0]      sel;
		res_t            res;
	} uop_t;

	typedef struct packed {
		uop_t            uop;
		logic            mul_en;
		logic            wb_en;
		logic            load_en;
		logic [LD_W-1:0] ld_cnt;
		logic [1:0]      comp;
		logic            out_load;
		logic            ready;
		logic            clear;
	} ctrl_t;

	function automatic uop_t mk(kind_t k, int ra, int rb, int rd, int sel, res_t r);
		uop_t u;
		u.kind = k;
		u.ra   = RA_W'(ra);
		u.rb   = RA_W'(rb);
		u.rd   = RA_W'(rd);
		u.sel  = 2'(sel);
		u.res  = r;
		return u;
	endfunction

	// Registers 0..7 hold the corners of one component, 8..11 are scratch.
	function automatic uop_t prog_rom(logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			6'd0:  u = mk(K_PSUB, 8, 8, 8, 0, RES_PNEG);
			6'd1:  u = mk(K_SLO,  8, 8, 9, 0, RES_NONE);
			6'd2:  u = mk(K_SHI,  8, 9, 9, 0, RES_PQ);
			6'd3:  u = mk(K_PSUB, 8, 8, 8, 1, RES_PNEG);
			6'd4:  u = mk(K_SLO,  8, 8, 9, 1, RES_NONE);
			6'd5:  u = mk(K_SHI,  8, 9, 9, 1, RES_PQ);
			6'd6:  u = mk(K_PSUB, 8, 8, 8, 2, RES_PNEG);
			6'd7:  u = mk(K_SLO,  8, 8, 9, 2, RES_NONE);
			6'd8:  u = mk(K_SHI,  8, 9, 9, 2, RES_PQ);
			6'd9:  u = mk(K_SUB,  0, 1, 8, 0, RES_NONE);
			6'd10: u = mk(K_SUB,  2, 3, 9, 0, RES_NONE);
			6'd11: u = mk(K_SUB,  4, 5, 10, 0, RES_NONE);
			6'd12: u = mk(K_SUB,  6, 7, 11, 0, RES_NONE);
			6'd13: u = mk(K_BLD,  8, 9, 8, 1, RES_NONE);
			6'd14: u = mk(K_BLD,  10, 11, 10, 1, RES_NONE);
			6'd15: u = mk(K_BLD,  8, 10, 8, 2, RES_NONE);
			6'd16: u = mk(K_SLO,  8, 8, 9, 0, RES_NONE);
			6'd17: u = mk(K_SHI,  8, 9, 9, 0, RES_DX);
			6'd18: u = mk(K_SUB,  0, 2, 8, 0, RES_NONE);
			6'd19: u = mk(K_SUB,  1, 3, 9, 0, RES_NONE);
			6'd20: u = mk(K_SUB,  4, 6, 10, 0, RES_NONE);
			6'd21: u = mk(K_SUB,  5, 7, 11, 0, RES_NONE);
			6'd22: u = mk(K_BLD,  8, 9, 8, 0, RES_NONE);
			6'd23: u = mk(K_BLD,  10, 11, 10, 0, RES_NONE);
			6'd24: u = mk(K_BLD,  8, 10, 8, 2, RES_NONE);
			6'd25: u = mk(K_SLO,  8, 8, 9, 1, RES_NONE);
			6'd26: u = mk(K_SHI,  8, 9, 9, 1, RES_DY);
			6'd27: u = mk(K_SUB,  0, 4, 8, 0, RES_NONE);
			6'd28: u = mk(K_SUB,  1, 5, 9, 0, RES_NONE);
			6'd29: u = mk(K_SUB,  2, 6, 10, 0, RES_NONE);
			6'd30: u = mk(K_SUB,  3, 7, 11, 0, RES_NONE);
			6'd31: u = mk(K_BLD,  8, 9, 8, 0, RES_NONE);
			6'd32: u = mk(K_BLD,  10, 11, 10, 0, RES_NONE);
			6'd33: u = mk(K_BLD,  8, 10, 8, 1, RES_NONE);
			6'd34: u = mk(K_SLO,  8, 8, 9, 2, RES_NONE);
			6'd35: u = mk(K_SHI,  8, 9, 9, 2, RES_DZ);
			6'd36: u = mk(K_BLD,  0, 1, 8, 0, RES_NONE);
			6'd37: u = mk(K_BLD,  2, 3, 9, 0, RES_NONE);
			6'd38: u = mk(K_BLD,  4, 5, 10, 0, RES_NONE);
			6'd39: u = mk(K_BLD,  6, 7, 11, 0, RES_NONE);
			6'd40: u = mk(K_BLD,  8, 9, 8, 1, RES_NONE);
			6'd41: u = mk(K_BLD,  10, 11, 10, 1, RES_NONE);
			6'd42: u = mk(K_BLD,  8, 10, 8, 2, RES_FLD);
			default: u = mk(K_SUB, 0, 0, 0, 0, RES_NONE);
		endcase
		return u;
	endfunction

endpackage

/* src/gfti_in_if.sv */
// Input item channel: grid sample writes and field queries.
interface gfti_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [14:0]        grid_index;
	logic signed [31:0] sample_bx;
	logic signed [31:0] sample_by;
	logic signed [31:0] sample_bz;

	modport source (output valid, op, pos_x, pos_y, pos_z, grid_index,
		sample_bx, sample_by, sample_bz, input ready);
	modport sink (input valid, op, pos_x, pos_y, pos_z, grid_index,
		sample_bx, sample_by, sample_bz, output ready);
endinterface

/* src/gfti_out_if.sv */
// Result item channel: interpolated field and its nine derivatives.
interface gfti_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] field_x;
	logic signed [31:0] field_y;
	logic signed [31:0] field_z;
	logic signed [47:0] dbx_dx;
	logic signed [47:0] dbx_dy;
	logic signed [47:0] dbx_dz;
	logic signed [47:0] dby_dx;
	logic signed [47:0] dby_dy;
	logic signed [47:0] dby_dz;
	logic signed [47:0] dbz_dx;
	logic signed [47:0] dbz_dy;
	logic signed [47:0] dbz_dz;

	modport source (output valid, field_x, field_y, field_z, dbx_dx, dbx_dy, dbx_dz,
		dby_dx, dby_dy, dby_dz, dbz_dx, dbz_dy, dbz_dz, input ready);
	modport sink (input valid, field_x, field_y, field_z, dbx_dx, dbx_dy, dbx_dz,
		dby_dx, dby_dy, dby_dz, dbz_dx, dbz_dy, dbz_dz, output ready);
endinterface

/* src/gfti_cfg_if.sv */
// Configuration write channel.
interface gfti_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/grid_field_trilinear_interpolator_core.sv */
// Top level of the trilinear field interpolator with gradient.
//
//  channel | modport | carries
//  --------+---------+---------------------------------------------------
//  req     | sink    | op, pos_x/y/z, grid_index, sample_bx/by/bz
//  rsp     | source  | field_x/y/z and the nine derivatives dbX_dY
//  cfg     | sink    | index, data (always ready)
//
// A write item is taken while idle and leaves the block ready. A query walks each
// step of the shared multiply unit through read, multiply and write-back: 9 position
// steps and a cell check, then per component a load of the eight corners and 34 steps;
// an outside query ends after the cell check, one with the map invalid goes straight to the result.
// Reset clears control and configuration; the sample stores are not cleared.
// The result waits in an output register; a new item is taken meanwhile.
module grid_field_trilinear_interpolator_core import gfti_pkg::*; #(
	parameter int GRID_NX = 32,
	parameter int GRID_NY = 32,
	parameter int GRID_NZ = 32
) (
	input  logic clk,
	input  logic arst_n,
	gfti_in_if.sink   req,
	gfti_out_if.source rsp,
	gfti_cfg_if.sink  cfg
);
	localparam int BASE_W = 3 * JW + 2;
	localparam logic [SAW-1:0] OFF_Y = SAW'(GRID_NX % STORE_DEPTH);
	localparam logic [SAW-1:0] OFF_Z = SAW'((GRID_NX * GRID_NY) % STORE_DEPTH);

	ctrl_t ctrl;

	logic               map_valid_q;
	logic signed [31:0] origin_q [3];
	logic [31:0]        inv_q [3];
	logic signed [31:0] pos_q [3];

	logic               neg_q [3];
	logic               big_q [3];
	logic [FW-1:0]      f_q [3];
	logic [JW-1:0]      j_q [3];
	logic [SAW-1:0]     base_q;
	logic signed [31:0] fld_q [3];
	logic signed [DW-1:0] der_q [3][3];

	logic               rsp_valid_q;
	logic signed [31:0] out_fld_q [3];
	logic signed [DW-1:0] out_der_q [3][3];

	logic               wr_acc;
	logic               in_grid;
	logic               rsp_free;
	logic [BASE_W-1:0]  base_w;
	logic [SAW-1:0]     corner_addr;
	logic [2:0]         k;
	logic [31:0]        rd_bx, rd_by, rd_bz, rd_sel;
	logic               rf_we;
	logic [RA_W-1:0]    rf_waddr;
	logic [RW-1:0]      rf_wdata;
	logic [RW-1:0]      rf_a, rf_b;
	logic signed [MA_W-1:0] ext_val;
	logic signed [RW-1:0]   mac_res;
	logic [RW-FW-1:0]   lim;

	function automatic logic signed [DW-1:0] sat_d(logic signed [RW-1:0] v);
		logic signed [DW-1:0] r;
		if (v[RW-1] && !(&v[RW-2:DW-1])) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else if (!v[RW-1] && (|v[RW-2:DW-1])) begin
			r = {1'b0, {(DW-1){1'b1}}};
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

	assign cfg.ready = 1'b1;
	assign req.ready = ctrl.ready;
	assign wr_acc = req.valid && ctrl.ready && (req.op == OP_WRITE);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign in_grid = !neg_q[0] && !neg_q[1] && !neg_q[2] && !big_q[0] && !big_q[1] && !big_q[2];

	gfti_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_op   (req.op),
		.map_valid(map_valid_q),
		.in_grid  (in_grid),
		.rsp_free (rsp_free),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= 1'b0;
			origin_q <= '{default: '0};
			inv_q <= '{default: '0};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MAP_VALID: map_valid_q <= cfg.data[0];
				CFG_ORIGIN_X:  origin_q[0] <= cfg.data;
				CFG_ORIGIN_Y:  origin_q[1] <= cfg.data;
				CFG_ORIGIN_Z:  origin_q[2] <= cfg.data;
				CFG_INV_X:     inv_q[0] <= cfg.data;
				CFG_INV_Y:     inv_q[1] <= cfg.data;
				CFG_INV_Z:     inv_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sample stores, written by write items and read one corner a cycle.
	assign k = ctrl.ld_cnt[2:0];
	assign corner_addr = base_q + (k[0] ? SAW'(1) : SAW'(0)) + (k[1] ? OFF_Y : SAW'(0))
		+ (k[2] ? OFF_Z : SAW'(0));

	gfti_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store_bx (
		.clk(clk), .we(wr_acc), .waddr(req.grid_index), .wdata(req.sample_bx),
		.raddr_a(corner_addr), .raddr_b(corner_addr), .rdata_a(rd_bx), .rdata_b()
	);
	gfti_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store_by (
		.clk(clk), .we(wr_acc), .waddr(req.grid_index), .wdata(req.sample_by),
		.raddr_a(corner_addr), .raddr_b(corner_addr), .rdata_a(rd_by), .rdata_b()
	);
	gfti_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store_bz (
		.clk(clk), .we(wr_acc), .waddr(req.grid_index), .wdata(req.sample_bz),
		.raddr_a(corner_addr), .raddr_b(corner_addr), .rdata_a(rd_bz), .rdata_b()
	);

	always_comb begin
		unique case (ctrl.comp)
			2'd0: rd_sel = rd_bx;
			2'd1: rd_sel = rd_by;
			default: rd_sel = rd_bz;
		endcase
	end

	// Working registers: corners arrive during the load, step results otherwise.
	assign rf_we = ctrl.wb_en || (ctrl.load_en && (ctrl.ld_cnt != '0));
	assign rf_waddr = ctrl.load_en ? RA_W'(ctrl.ld_cnt - LD_W'(1)) : ctrl.uop.rd;
	assign rf_wdata = ctrl.load_en ? RW'($signed(rd_sel)) : mac_res;

	gfti_ram #(.WIDTH(RW), .DEPTH(RF_DEPTH)) u_regs (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr_a(ctrl.uop.ra), .raddr_b(ctrl.uop.rb), .rdata_a(rf_a), .rdata_b(rf_b)
	);

	assign ext_val = MA_W'(pos_q[ctrl.uop.sel]) - MA_W'(origin_q[ctrl.uop.sel]);

	gfti_mac u_mac (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.kind   (ctrl.uop.kind),
		.a_val  ($signed(rf_a)),
		.b_val  ($signed(rf_b)),
		.ext_val(ext_val),
		.fval   (f_q[ctrl.uop.sel]),
		.klo    (inv_q[ctrl.uop.sel][FW-1:0]),
		.khi    (inv_q[ctrl.uop.sel][31:FW]),
		.result (mac_res)
	);

	always_comb begin
		unique case (ctrl.uop.sel)
			2'd0: lim = (RW-FW)'(GRID_NX - 1);
			2'd1: lim = (RW-FW)'(GRID_NY - 1);
			default: lim = (RW-FW)'(GRID_NZ - 1);
		endcase
	end

	assign base_w = BASE_W'(j_q[0]) + BASE_W'(GRID_NX)
		* (BASE_W'(j_q[1]) + BASE_W'(GRID_NY) * BASE_W'(j_q[2]));

	// The scaled position holds the cell index from bit 16 up and the fraction below.
	always_ff @(posedge clk) begin
		base_q <= base_w[SAW-1:0];
		if (req.valid && ctrl.ready && (req.op == OP_QUERY)) begin
			pos_q[0] <= req.pos_x;
			pos_q[1] <= req.pos_y;
			pos_q[2] <= req.pos_z;
		end
		if (ctrl.clear) begin
			fld_q <= '{default: '0};
			der_q <= '{default: '{default: '0}};
		end else if (ctrl.wb_en) begin
			unique case (ctrl.uop.res)
				RES_PNEG: neg_q[ctrl.uop.sel] <= mac_res[RW-1];
				RES_PQ: begin
					f_q[ctrl.uop.sel] <= mac_res[FW-1:0];
					j_q[ctrl.uop.sel] <= mac_res[FW+JW-1:FW];
					big_q[ctrl.uop.sel] <= (mac_res[RW-1:FW] >= lim);
				end
				RES_FLD: fld_q[ctrl.comp] <= mac_res[31:0];
				RES_DX:  der_q[ctrl.comp][0] <= sat_d(mac_res);
				RES_DY:  der_q[ctrl.comp][1] <= sat_d(mac_res);
				RES_DZ:  der_q[ctrl.comp][2] <= sat_d(mac_res);
				default: ;
			endcase
		end
		if (ctrl.out_load) begin
			out_fld_q <= fld_q;
			out_der_q <= der_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.field_x = out_fld_q[0];
	assign rsp.field_y = out_fld_q[1];
	assign rsp.field_z = out_fld_q[2];
	assign rsp.dbx_dx  = out_der_q[0][0];
	assign rsp.dbx_dy  = out_der_q[0][1];
	assign rsp.dbx_dz  = out_der_q[0][2];
	assign rsp.dby_dx  = out_der_q[1][0];
	assign rsp.dby_dy  = out_der_q[1][1];
	assign rsp.dby_dz  = out_der_q[1][2];
	assign rsp.dbz_dx  = out_der_q[2][0];
	assign rsp.dbz_dy  = out_der_q[2][1];
	assign rsp.dbz_dz  = out_der_q[2][2];
endmodule

/* src/gfti_ram.sv */
// Generic RAM with one write port and two registered read ports.
module gfti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

/* src/gfti_mac.sv */
// Shared multiply-accumulate unit: blends, differences and scaling steps.
module gfti_mac import gfti_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  kind_t                  kind,
	input  logic signed [RW-1:0]   a_val,
	input  logic signed [RW-1:0]   b_val,
	input  logic signed [MA_W-1:0] ext_val,
	input  logic [FW-1:0]          fval,
	input  logic [FW-1:0]          klo,
	input  logic [FW-1:0]          khi,
	output logic signed [RW-1:0]   result
);
	logic signed [PW-1:0]   diff;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [RW-1:0]   addend;
	logic                   shr;
	logic signed [PW-1:0]   prod_q;
	logic signed [RW-1:0]   addend_q;
	logic                   shr_q;
	logic signed [PW-1:0]   sum;

	always_comb begin
		diff = PW'(b_val) - PW'(a_val);
		unique case (kind)
			K_SUB: begin
				mul_a = $signed(diff[MA_W-1:0]);
				mul_b = MB_W'(1);
				addend = '0;
				shr = 1'b0;
			end
			// a + floor((b - a) * f / 2^16) equals the two-weight blend exactly.
			K_BLD: begin
				mul_a = $signed(diff[MA_W-1:0]);
				mul_b = $signed({1'b0, fval});
				addend = a_val;
				shr = 1'b1;
			end
			K_SLO: begin
				mul_a = $signed(a_val[MA_W-1:0]);
				mul_b = $signed({1'b0, klo});
				addend = '0;
				shr = 1'b1;
			end
			K_SHI: begin
				mul_a = $signed(a_val[MA_W-1:0]);
				mul_b = $signed({1'b0, khi});
				addend = b_val;
				shr = 1'b0;
			end
			K_PSUB: begin
				mul_a = ext_val;
				mul_b = MB_W'(1);
				addend = '0;
				shr = 1'b0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				addend = '0;
				shr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
			addend_q <= addend;
			shr_q <= shr;
		end
	end

	// The arithmetic shift gives the floor of a negative product.
	assign sum = PW'(addend_q) + (shr_q ? (prod_q >>> FW) : prod_q);
	assign result = sum[RW-1:0];
endmodule

/* src/gfti_seq.sv */
// Sequencer: walks the step program over the shared unit and loads corners.
module gfti_seq import gfti_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  logic  req_op,
	input  logic  map_valid,
	input  logic  in_grid,
	input  logic  rsp_free,
	output ctrl_t ctrl
);
	state_t          state_q;
	state_t          state_d;
	logic [PC_W-1:0] pc_q;
	logic [1:0]      comp_q;
	logic [LD_W-1:0] ld_q;
	logic            start;

	assign start = (state_q == S_IDLE) && req_valid && (req_op == OP_QUERY);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = map_valid ? S_RD : S_DONE;
				end
			end
			S_RD:  state_d = S_MUL;
			S_MUL: state_d = S_WB;
			S_WB: begin
				if (pc_q == PC_W'(POS_LEN - 1)) begin
					state_d = S_CHK;
				end else if (pc_q == PC_W'(PROG_LEN - 1)) begin
					state_d = (comp_q == 2'd2) ? S_DONE : S_LOAD;
				end else begin
					state_d = S_RD;
				end
			end
			S_CHK: state_d = in_grid ? S_LOAD : S_DONE;
			S_LOAD: begin
				if (ld_q == LD_W'(LD_LAST)) begin
					state_d = S_RD;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			comp_q <= '0;
			ld_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: pc_q <= '0;
				S_WB: begin
					if (state_d == S_RD) begin
						pc_q <= pc_q + PC_W'(1);
					end else if (state_d == S_LOAD) begin
						pc_q <= PC_W'(POS_LEN);
						comp_q <= comp_q + 2'd1;
						ld_q <= '0;
					end
				end
				S_CHK: begin
					pc_q <= PC_W'(POS_LEN);
					comp_q <= '0;
					ld_q <= '0;
				end
				S_LOAD: ld_q <= ld_q + LD_W'(1);
				default: ;
			endcase
		end
	end

	always_comb begin
		ctrl.uop = prog_rom(pc_q);
		ctrl.mul_en = (state_q == S_MUL);
		ctrl.wb_en = (state_q == S_WB);
		ctrl.load_en = (state_q == S_LOAD);
		ctrl.ld_cnt = ld_q;
		ctrl.comp = comp_q;
		ctrl.out_load = (state_q == S_DONE) && rsp_free;
		ctrl.ready = (state_q == S_IDLE);
		ctrl.clear = start;
	end
endmodule

/* src/gfti_checker.sv */
// Port-level assertions for the interpolator core, bound to the top level.
module gfti_checker import gfti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_op,
	input logic rsp_valid,
	input logic rsp_ready
);
	// A query keeps the block busy for at least the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_op == OP_QUERY)) |=> !req_ready)
		else $error("block ready right after a query item");

	// After a write item the block is ready again in the next cycle.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_op == OP_WRITE)) |=> req_ready)
		else $error("block busy after a write item");

	// A new result only appears after a busy cycle of the sequencer.
	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a query in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result item dropped while stalled");
endmodule

bind grid_field_trilinear_interpolator_core gfti_checker u_gfti_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_op   (req.op),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready)
);
